// File: rtl/core/stroke_join_solver_assert.svh
// Assertion macros for the stroke join solver.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef STROKE_JOIN_SOLVER_ASSERT_SVH
`define STROKE_JOIN_SOLVER_ASSERT_SVH

// same-cycle implication
`define SJS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SJS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sjs_pkg.sv
// Package for the stroke join solver: join kinds, limits, divider control word.
// No dependencies.
`default_nettype none

package sjs_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int LIMIT_BITS     = 26;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 26'd32768;

    // per-axis miter distance clamp (2^13) and its squares
    localparam int CLAMP_BITS = 14;
    localparam logic [CLAMP_BITS-1:0] DIST_CLAMP = 14'd8192;
    localparam int SQ_BITS    = 2 * CLAMP_BITS - 1;
    localparam int SUM_BITS   = SQ_BITS + 1;

    typedef enum logic [1:0] {
        JK_NONE  = 2'd0,
        JK_MITER = 2'd1,
        JK_BEVEL = 2'd2
    } t_join_kind;

    // control word that enters the divider pipe with each word
    typedef struct packed {
        logic vld;
        logic neg_x;
        logic neg_y;
    } t_div_ctl;

endpackage

`default_nettype wire

// File: rtl/core/sjs_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on sjs_pkg (t_div_ctl). Top quotient bit flags overflow; magnitude saturates.
`default_nettype none

module sjs_div #(
    parameter int RW  = 82,
    parameter int DDW = 52,
    parameter int QB  = 27,
    parameter int SW  = 242
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sjs_pkg::t_div_ctl    i_ctl,
    input  wire logic [RW-1:0]        i_nx,
    input  wire logic [RW-1:0]        i_ny,
    input  wire logic [DDW-1:0]       i_d,
    input  wire logic [SW-1:0]        i_side,
    output logic                      o_vld,
    output logic signed [QB:0]        o_qx,
    output logic signed [QB:0]        o_qy,
    output logic [SW-1:0]             o_side
);

    // stage arrays, index 0 is the input word
    logic            s_vld  [QB+2];
    logic            s_negx [QB+2];
    logic            s_negy [QB+2];
    logic [RW-1:0]   s_rx   [QB+2];
    logic [RW-1:0]   s_ry   [QB+2];
    logic [DDW-1:0]  s_d    [QB+2];
    logic [QB:0]     s_qx   [QB+2];
    logic [QB:0]     s_qy   [QB+2];
    logic [SW-1:0]   s_side [QB+2];

    assign s_vld[0]  = i_ctl.vld;
    assign s_negx[0] = i_ctl.neg_x;
    assign s_negy[0] = i_ctl.neg_y;
    assign s_rx[0]   = i_nx;
    assign s_ry[0]   = i_ny;
    assign s_d[0]    = i_d;
    assign s_qx[0]   = '0;
    assign s_qy[0]   = '0;
    assign s_side[0] = i_side;

    genvar gi;
    for (gi = 0; gi <= QB; gi++) begin : g_stage
        logic [RW-1:0] sh;
        logic          gex;
        logic          gey;

        // trial subtract of the divisor at this bit weight
        always_comb begin
            sh  = RW'(s_d[gi]) << (QB - gi);
            gex = (s_rx[gi] >= sh);
            gey = (s_ry[gi] >= sh);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_vld[gi+1] <= 1'b0;
            end else begin
                s_vld[gi+1] <= s_vld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            s_rx[gi+1]   <= gex ? (s_rx[gi] - sh) : s_rx[gi];
            s_ry[gi+1]   <= gey ? (s_ry[gi] - sh) : s_ry[gi];
            s_qx[gi+1]   <= {s_qx[gi][QB-1:0], gex};
            s_qy[gi+1]   <= {s_qy[gi][QB-1:0], gey};
            s_d[gi+1]    <= s_d[gi];
            s_negx[gi+1] <= s_negx[gi];
            s_negy[gi+1] <= s_negy[gi];
            s_side[gi+1] <= s_side[gi];
        end
    end

    // saturate on overflow, then apply sign
    logic [QB-1:0] magx;
    logic [QB-1:0] magy;

    always_comb begin
        magx = s_qx[QB+1][QB] ? {QB{1'b1}} : s_qx[QB+1][QB-1:0];
        magy = s_qy[QB+1][QB] ? {QB{1'b1}} : s_qy[QB+1][QB-1:0];
        o_qx = s_negx[QB+1] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        o_qy = s_negy[QB+1] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    end

    assign o_vld  = s_vld[QB+1];
    assign o_side = s_side[QB+1];

endmodule

`default_nettype wire

// File: rtl/core/stroke_join_solver.sv
// Stroke join solver top level: miter / bevel / midpoint join of two offset edges.
// Depends on sjs_pkg, sjs_div and stroke_join_solver_assert.svh.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------
//  input     | start, busy       | i_prev_*, i_cur_*, i_*_dir_* (12 coords)
//  result    | o_done strobe     | o_join_kind, o_join_x/y, o_bevel_x/y
//  config    | i_cfg_we          | i_cfg_wdata (miter limit squared)
//
// One word accepted per cycle; busy is never raised.
// The pipe has six front stages (differences, products,
// numerator/denominator, split multiply, sum, dividend), a COORD_BITS + 4 stage
// bit-per-stage divider, then four stages: point, distance, squares, selection.
// Synchronous reset clears only valid bits and sets the limit to LIMIT_RESET.
// Results cannot be held off; each stays on the ports for one cycle.
`default_nettype none

`include "stroke_join_solver_assert.svh"

module stroke_join_solver #(
    parameter int COORD_BITS = sjs_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_end_y,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_end_y,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_dir_x,
    input  wire logic signed [COORD_BITS-1:0]  i_prev_dir_y,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_dir_x,
    input  wire logic signed [COORD_BITS-1:0]  i_cur_dir_y,
    input  wire logic                          i_cfg_we,
    input  wire logic [sjs_pkg::LIMIT_BITS-1:0] i_cfg_wdata,
    output logic                               o_done,
    output logic [1:0]                         o_join_kind,
    output logic signed [COORD_BITS-1:0]       o_join_x,
    output logic signed [COORD_BITS-1:0]       o_join_y,
    output logic signed [COORD_BITS-1:0]       o_bevel_x,
    output logic signed [COORD_BITS-1:0]       o_bevel_y
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;          // edge differences
    localparam int PW  = 2 * DW;         // cross products
    localparam int NW  = PW + 1;         // numerator / denominator
    localparam int NL  = (NW + 1) / 2;   // low slice of numerator
    localparam int NH  = NW - NL;        // high slice, signed
    localparam int PL  = DW + NL + 1;
    localparam int PH  = DW + NH;
    localparam int PW3 = DW + NW;        // span * numerator
    localparam int QB  = C + 3;          // quotient magnitude bits
    localparam int DDW = NW + 1;         // divisor 2|den|
    localparam int RW  = PW3 + 3;        // dividend / remainder
    localparam int SW0 = 10 * C;
    localparam int SW  = SW0 + 2;
    localparam int XW  = QB + 2;         // intersection coordinate
    localparam int LAT = QB + 11;

    localparam logic signed [C-1:0]  CMAX  = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0]  CMIN  = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [XW-1:0] XMAX  = XW'(CMAX);
    localparam logic signed [XW-1:0] XMIN  = XW'(CMIN);

    function automatic logic signed [C-1:0] sat_dw(input logic signed [C:0] v);
        if (v[C] != v[C-1]) begin
            return v[C] ? CMIN : CMAX;
        end
        return v[C-1:0];
    endfunction

    function automatic logic signed [C-1:0] sat_xw(input logic signed [XW-1:0] v);
        if (v > XMAX) begin
            return CMAX;
        end
        if (v < XMIN) begin
            return CMIN;
        end
        return v[C-1:0];
    endfunction

    assign busy = 1'b0;

    // limit register
    logic [sjs_pkg::LIMIT_BITS-1:0] r_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sjs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // valid bits of the front and back stages
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic r7_vld, r8_vld, r9_vld, r10_vld;
    logic dv_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else begin
            r1_vld  <= start && !busy;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= dv_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    // S1: edge differences, midpoint and bevel corners
    logic signed [DW-1:0] r1_abx, r1_aby, r1_cdx, r1_cdy, r1_acx, r1_acy;
    logic [SW0-1:0]       r1_side;
    logic signed [DW-1:0] n1_sx, n1_sy;

    always_comb begin
        n1_sx = DW'(i_prev_end_x) + DW'(i_cur_start_x);
        n1_sy = DW'(i_prev_end_y) + DW'(i_cur_start_y);
    end

    always_ff @(posedge i_clk) begin
        r1_abx  <= DW'(i_prev_end_x) - DW'(i_prev_start_x);
        r1_aby  <= DW'(i_prev_end_y) - DW'(i_prev_start_y);
        r1_cdx  <= DW'(i_cur_end_x) - DW'(i_cur_start_x);
        r1_cdy  <= DW'(i_cur_end_y) - DW'(i_cur_start_y);
        r1_acx  <= DW'(i_prev_start_x) - DW'(i_cur_start_x);
        r1_acy  <= DW'(i_prev_start_y) - DW'(i_cur_start_y);
        r1_side <= {i_prev_start_x, i_prev_start_y, i_prev_end_x, i_prev_end_y,
                    n1_sx[C:1], n1_sy[C:1],
                    sat_dw(DW'(i_prev_end_x) + DW'(i_prev_dir_x)),
                    sat_dw(DW'(i_prev_end_y) + DW'(i_prev_dir_y)),
                    sat_dw(DW'(i_cur_start_x) - DW'(i_cur_dir_x)),
                    sat_dw(DW'(i_cur_start_y) - DW'(i_cur_dir_y))};
    end

    // S2: four cross products
    logic signed [PW-1:0] r2_m1, r2_m2, r2_m3, r2_m4;
    logic signed [DW-1:0] r2_abx, r2_aby;
    logic [SW0-1:0]       r2_side;

    always_ff @(posedge i_clk) begin
        r2_m1   <= PW'(r1_acy) * PW'(r1_cdx);
        r2_m2   <= PW'(r1_cdy) * PW'(r1_acx);
        r2_m3   <= PW'(r1_abx) * PW'(r1_cdy);
        r2_m4   <= PW'(r1_cdx) * PW'(r1_aby);
        r2_abx  <= r1_abx;
        r2_aby  <= r1_aby;
        r2_side <= r1_side;
    end

    // S3: numerator and denominator of t
    logic signed [NW-1:0] r3_num, r3_den;
    logic signed [DW-1:0] r3_abx, r3_aby;
    logic [SW0-1:0]       r3_side;

    always_ff @(posedge i_clk) begin
        r3_num  <= NW'(r2_m1) - NW'(r2_m2);
        r3_den  <= NW'(r2_m3) - NW'(r2_m4);
        r3_abx  <= r2_abx;
        r3_aby  <= r2_aby;
        r3_side <= r2_side;
    end

    // S4: span * num in two slices, t range test, |den|
    logic [NW-1:0]        n4_absn, n4_absd;
    logic                 n4_out;
    logic signed [PL-1:0] r4_pxl, r4_pyl;
    logic signed [PH-1:0] r4_pxh, r4_pyh;
    logic [NW-1:0]        r4_absd;
    logic                 r4_dneg;
    logic [SW-1:0]        r4_side;

    always_comb begin
        n4_absn = r3_num[NW-1] ? NW'(-r3_num) : NW'(r3_num);
        n4_absd = r3_den[NW-1] ? NW'(-r3_den) : NW'(r3_den);
        n4_out  = (r3_num != '0) &&
                  ((r3_num[NW-1] != r3_den[NW-1]) || (n4_absn > n4_absd));
    end

    always_ff @(posedge i_clk) begin
        r4_pxl  <= PL'(r3_abx) * PL'($signed({1'b0, r3_num[NL-1:0]}));
        r4_pyl  <= PL'(r3_aby) * PL'($signed({1'b0, r3_num[NL-1:0]}));
        r4_pxh  <= PH'(r3_abx) * PH'($signed(r3_num[NW-1:NL]));
        r4_pyh  <= PH'(r3_aby) * PH'($signed(r3_num[NW-1:NL]));
        r4_absd <= n4_absd;
        r4_dneg <= r3_den[NW-1];
        r4_side <= {r3_side, n4_out, (r3_den == '0)};
    end

    // S5: recombine slices
    logic signed [PW3-1:0] r5_px, r5_py;
    logic [NW-1:0]         r5_absd;
    logic                  r5_dneg;
    logic [SW-1:0]         r5_side;

    always_ff @(posedge i_clk) begin
        r5_px   <= (PW3'(r4_pxh) <<< NL) + PW3'(r4_pxl);
        r5_py   <= (PW3'(r4_pyh) <<< NL) + PW3'(r4_pyl);
        r5_absd <= r4_absd;
        r5_dneg <= r4_dneg;
        r5_side <= r4_side;
    end

    // S6: rounding dividend 2|p|+|d| and divisor 2|d|
    logic [PW3-1:0]    n6_apx, n6_apy;
    logic [RW-1:0]     r6_nx, r6_ny;
    logic [DDW-1:0]    r6_d;
    logic              r6_negx, r6_negy;
    sjs_pkg::t_div_ctl n6_ctl;
    logic [SW-1:0]     r6_side;

    always_comb begin
        n6_apx = r5_px[PW3-1] ? PW3'(-r5_px) : PW3'(r5_px);
        n6_apy = r5_py[PW3-1] ? PW3'(-r5_py) : PW3'(r5_py);
    end

    always_ff @(posedge i_clk) begin
        r6_nx      <= (RW'(n6_apx) << 1) + RW'(r5_absd);
        r6_ny      <= (RW'(n6_apy) << 1) + RW'(r5_absd);
        r6_d       <= {r5_absd, 1'b0};
        r6_negx    <= r5_px[PW3-1] ^ r5_dneg;
        r6_negy    <= r5_py[PW3-1] ^ r5_dneg;
        r6_side    <= r5_side;
    end
    assign n6_ctl = '{vld: r6_vld, neg_x: r6_negx, neg_y: r6_negy};

    // divider pipe
    logic signed [QB:0] dv_qx, dv_qy;
    logic [SW-1:0]      dv_side;

    sjs_div #(
        .RW  (RW),
        .DDW (DDW),
        .QB  (QB),
        .SW  (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n6_ctl),
        .i_nx    (r6_nx),
        .i_ny    (r6_ny),
        .i_d     (r6_d),
        .i_side  (r6_side),
        .o_vld   (dv_vld),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy),
        .o_side  (dv_side)
    );

    logic signed [C-1:0] dv_ax, dv_ay, dv_bx, dv_by, dv_mx, dv_my;
    logic signed [C-1:0] dv_jx, dv_jy, dv_cx, dv_cy;
    logic                dv_out, dv_par;
    assign {dv_ax, dv_ay, dv_bx, dv_by, dv_mx, dv_my,
            dv_jx, dv_jy, dv_cx, dv_cy, dv_out, dv_par} = dv_side;

    // S7: intersection point
    logic signed [XW-1:0] r7_x, r7_y;
    logic signed [C-1:0]  r7_bx, r7_by, r7_mx, r7_my, r7_jx, r7_jy, r7_cx, r7_cy;
    logic                 r7_out, r7_par;

    always_ff @(posedge i_clk) begin
        r7_x   <= XW'(dv_ax) + XW'(dv_qx);
        r7_y   <= XW'(dv_ay) + XW'(dv_qy);
        r7_bx  <= dv_bx;
        r7_by  <= dv_by;
        r7_mx  <= dv_mx;
        r7_my  <= dv_my;
        r7_jx  <= dv_jx;
        r7_jy  <= dv_jy;
        r7_cx  <= dv_cx;
        r7_cy  <= dv_cy;
        r7_out <= dv_out;
        r7_par <= dv_par;
    end

    // S8: clamped distance from b, saturated miter point
    logic signed [XW-1:0] n8_ex, n8_ey;
    logic [XW-1:0]        n8_ax, n8_ay;
    logic [sjs_pkg::CLAMP_BITS-1:0] r8_cx2, r8_cy2;
    logic signed [C-1:0]  r8_sx, r8_sy, r8_mx, r8_my, r8_jx, r8_jy, r8_cx, r8_cy;
    logic                 r8_out, r8_par;

    always_comb begin
        n8_ex = r7_x - XW'(r7_bx);
        n8_ey = r7_y - XW'(r7_by);
        n8_ax = n8_ex[XW-1] ? XW'(-n8_ex) : XW'(n8_ex);
        n8_ay = n8_ey[XW-1] ? XW'(-n8_ey) : XW'(n8_ey);
    end

    always_ff @(posedge i_clk) begin
        r8_cx2 <= (n8_ax > XW'(sjs_pkg::DIST_CLAMP)) ? sjs_pkg::DIST_CLAMP
                                                     : n8_ax[sjs_pkg::CLAMP_BITS-1:0];
        r8_cy2 <= (n8_ay > XW'(sjs_pkg::DIST_CLAMP)) ? sjs_pkg::DIST_CLAMP
                                                     : n8_ay[sjs_pkg::CLAMP_BITS-1:0];
        r8_sx  <= sat_xw(r7_x);
        r8_sy  <= sat_xw(r7_y);
        r8_mx  <= r7_mx;
        r8_my  <= r7_my;
        r8_jx  <= r7_jx;
        r8_jy  <= r7_jy;
        r8_cx  <= r7_cx;
        r8_cy  <= r7_cy;
        r8_out <= r7_out;
        r8_par <= r7_par;
    end

    // S9: squares
    logic [sjs_pkg::SQ_BITS-1:0] r9_qx, r9_qy;
    logic signed [C-1:0] r9_sx, r9_sy, r9_mx, r9_my, r9_jx, r9_jy, r9_cx, r9_cy;
    logic                r9_out, r9_par;

    always_ff @(posedge i_clk) begin
        r9_qx  <= sjs_pkg::SQ_BITS'(r8_cx2 * r8_cx2);
        r9_qy  <= sjs_pkg::SQ_BITS'(r8_cy2 * r8_cy2);
        r9_sx  <= r8_sx;
        r9_sy  <= r8_sy;
        r9_mx  <= r8_mx;
        r9_my  <= r8_my;
        r9_jx  <= r8_jx;
        r9_jy  <= r8_jy;
        r9_cx  <= r8_cx;
        r9_cy  <= r8_cy;
        r9_out <= r8_out;
        r9_par <= r8_par;
    end

    // S10: limit compare and join selection
    logic [sjs_pkg::SUM_BITS-1:0] n10_sum;
    sjs_pkg::t_join_kind          n10_kind;

    always_comb begin
        n10_sum = sjs_pkg::SUM_BITS'(r9_qx) + sjs_pkg::SUM_BITS'(r9_qy);
        priority if (r9_par) begin
            n10_kind = sjs_pkg::JK_NONE;
        end else if (r9_out && (n10_sum > sjs_pkg::SUM_BITS'(r_limit))) begin
            n10_kind = sjs_pkg::JK_BEVEL;
        end else begin
            n10_kind = sjs_pkg::JK_MITER;
        end
    end

    sjs_pkg::t_join_kind r10_kind;
    logic signed [C-1:0] r10_jx, r10_jy, r10_bx, r10_by;

    always_ff @(posedge i_clk) begin
        r10_kind <= n10_kind;
        unique case (n10_kind)
            sjs_pkg::JK_NONE: begin
                r10_jx <= r9_mx;
                r10_jy <= r9_my;
                r10_bx <= '0;
                r10_by <= '0;
            end
            sjs_pkg::JK_BEVEL: begin
                r10_jx <= r9_jx;
                r10_jy <= r9_jy;
                r10_bx <= r9_cx;
                r10_by <= r9_cy;
            end
            default: begin
                r10_jx <= r9_sx;
                r10_jy <= r9_sy;
                r10_bx <= '0;
                r10_by <= '0;
            end
        endcase
    end

    assign o_done      = r10_vld;
    assign o_join_kind = r10_kind;
    assign o_join_x    = r10_jx;
    assign o_join_y    = r10_jy;
    assign o_bevel_x   = r10_bx;
    assign o_bevel_y   = r10_by;

    // checks
    `SJS_ASSERT_NXT(a_latency, start && !busy, ##(LAT-1) o_done, "result missing")
    `SJS_ASSERT_IMP(a_no_orphan, o_done, $past(start, LAT), "result without word")
    `SJS_ASSERT_IMP(a_bevel_zero, o_done && (o_join_kind != sjs_pkg::JK_BEVEL),
        (o_bevel_x == '0) && (o_bevel_y == '0), "bevel corner set on non-bevel")

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for stroke_join_solver: directed table, then random joins under several limits.
// Depends on sjs_pkg and stroke_join_solver; checks each result against a typed row or a predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 24;
    localparam int N_RANDOM = 550;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_WAIT = CB + 20;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [sjs_pkg::LIMIT_BITS-1:0] LIM_MAX = {sjs_pkg::LIMIT_BITS{1'b1}};

    // positions of the fields within one word
    localparam int AX = 0, AY = 1, BX = 2, BY = 3, CX = 4, CY = 5;
    localparam int DX = 6, DY = 7, PDX = 8, PDY = 9, QDX = 10, QDY = 11;

    typedef logic signed [CB-1:0] t_coord;
    typedef t_coord t_word [12];
    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [1:0] kind;
        t_coord     jx;
        t_coord     jy;
        t_coord     bvx;
        t_coord     bvy;
    } t_join;

    typedef struct {
        t_word f;
        bit    typed;
        t_join res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_coord     i_prev_start_x, i_prev_start_y, i_prev_end_x, i_prev_end_y;
    t_coord     i_cur_start_x, i_cur_start_y, i_cur_end_x, i_cur_end_y;
    t_coord     i_prev_dir_x, i_prev_dir_y, i_cur_dir_x, i_cur_dir_y;
    logic       i_cfg_we;
    logic [sjs_pkg::LIMIT_BITS-1:0] i_cfg_wdata;
    logic       o_done;
    logic [1:0] o_join_kind;
    t_coord     o_join_x, o_join_y, o_bevel_x, o_bevel_y;

    t_join      joins_due[$];
    logic [sjs_pkg::LIMIT_BITS-1:0] miter_limit;
    int         n_errors;
    int         n_words;
    int         kind_seen[3];
    int         idle_cycles;
    bit         allow_gaps;

    stroke_join_solver uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_prev_start_x (i_prev_start_x),
        .i_prev_start_y (i_prev_start_y),
        .i_prev_end_x   (i_prev_end_x),
        .i_prev_end_y   (i_prev_end_y),
        .i_cur_start_x  (i_cur_start_x),
        .i_cur_start_y  (i_cur_start_y),
        .i_cur_end_x    (i_cur_end_x),
        .i_cur_end_y    (i_cur_end_y),
        .i_prev_dir_x   (i_prev_dir_x),
        .i_prev_dir_y   (i_prev_dir_y),
        .i_cur_dir_x    (i_cur_dir_x),
        .i_cur_dir_y    (i_cur_dir_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_join_kind    (o_join_kind),
        .o_join_x       (o_join_x),
        .o_join_y       (o_join_y),
        .o_bevel_x      (o_bevel_x),
        .o_bevel_y      (o_bevel_y)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // clamp to the coordinate range
    function automatic t_coord sat_coord(input t_wide v);
        if (v > t_wide'(CMAX)) return CMAX;
        if (v < t_wide'(CMIN)) return CMIN;
        return v[CB-1:0];
    endfunction

    // base + span*num/den, rounded to nearest, ties away from zero
    function automatic t_wide lerp_round(input t_wide base, input t_wide span,
                                         input t_wide num, input t_wide den);
        t_wide p, ap, ad, q;
        p  = span * num;
        ap = (p < 0) ? -p : p;
        ad = (den < 0) ? -den : den;
        q  = (2 * ap + ad) / (2 * ad);
        return ((p < 0) != (den < 0)) ? base - q : base + q;
    endfunction

    // per-axis distance, magnitude clamped, squared
    function automatic t_wide clamp_sq(input t_wide d);
        t_wide a;
        a = (d < 0) ? -d : d;
        if (a > 8192) a = 8192;
        return a * a;
    endfunction

    // join of two offset edges under the given limit
    function automatic t_join solve_join(input t_word f,
                                         input logic [sjs_pkg::LIMIT_BITS-1:0] lim);
        t_join r;
        t_wide ax, ay, bx, by, cx, cy, dx, dy, num, den, x, y, sx, sy;
        bit outside;
        ax = f[AX]; ay = f[AY]; bx = f[BX]; by = f[BY];
        cx = f[CX]; cy = f[CY]; dx = f[DX]; dy = f[DY];
        num = (ay - cy) * (dx - cx) - (dy - cy) * (ax - cx);
        den = (bx - ax) * (dy - cy) - (dx - cx) * (by - ay);
        r.bvx = '0;
        r.bvy = '0;
        if (den == 0) begin
            sx = bx + cx;
            sy = by + cy;
            r.kind = sjs_pkg::JK_NONE;
            r.jx = t_coord'(sx >>> 1);
            r.jy = t_coord'(sy >>> 1);
            return r;
        end
        x = lerp_round(ax, bx - ax, num, den);
        y = lerp_round(ay, by - ay, num, den);
        if (num == 0) outside = 0;
        else if ((num < 0) != (den < 0)) outside = 1;
        else outside = ((num < 0) ? -num : num) > ((den < 0) ? -den : den);
        if (outside && (clamp_sq(x - bx) + clamp_sq(y - by) > t_wide'(lim))) begin
            r.kind = sjs_pkg::JK_BEVEL;
            r.jx  = sat_coord(bx + t_wide'(f[PDX]));
            r.jy  = sat_coord(by + t_wide'(f[PDY]));
            r.bvx = sat_coord(cx - t_wide'(f[QDX]));
            r.bvy = sat_coord(cy - t_wide'(f[QDY]));
            return r;
        end
        r.kind = sjs_pkg::JK_MITER;
        r.jx = sat_coord(x);
        r.jy = sat_coord(y);
        return r;
    endfunction

    function automatic t_coord rnd_span(input int span);
        return t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // random word; mostly small geometry so miters and bevels both show up
    function automatic t_word rand_word();
        t_word f;
        int sel, k;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) f[i] = rnd_span(4096);
        if (sel < 2) begin
            for (int i = 0; i < 12; i++) f[i] = t_coord'($urandom);
        end else if (sel < 4) begin
            // parallel edges: d - c is a multiple of b - a
            k = int'($urandom_range(0, 6)) - 3;
            f[DX] = f[CX] + t_coord'(k * (f[BX] - f[AX]));
            f[DY] = f[CY] + t_coord'(k * (f[BY] - f[AY]));
        end else if (sel == 4) begin
            // push bevel corners and miters toward saturation
            f[BX]  = CMAX - rnd_span(64) - 64;
            f[BY]  = CMIN + rnd_span(64) + 64;
            f[PDX] = t_coord'($urandom);
            f[PDY] = t_coord'($urandom);
            f[QDX] = t_coord'($urandom);
            f[QDY] = t_coord'($urandom);
            f[AX]  = f[BX] - rnd_span(300);
        end else if (sel == 5) begin
            for (int i = 0; i < 8; i++) f[i] = rnd_span(32);
        end
        return f;
    endfunction

    // drive one word and hold it until taken
    task automatic send_word(input t_word f, input bit typed, input t_join res);
        i_prev_start_x <= f[AX];  i_prev_start_y <= f[AY];
        i_prev_end_x   <= f[BX];  i_prev_end_y   <= f[BY];
        i_cur_start_x  <= f[CX];  i_cur_start_y  <= f[CY];
        i_cur_end_x    <= f[DX];  i_cur_end_y    <= f[DY];
        i_prev_dir_x   <= f[PDX]; i_prev_dir_y   <= f[PDY];
        i_cur_dir_x    <= f[QDX]; i_cur_dir_y    <= f[QDY];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        joins_due.insert(joins_due.size(), typed ? res : solve_join(f, miter_limit));
        n_words++;
        if (allow_gaps && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // drain the pipe, then write the limit
    task automatic set_limit(input logic [sjs_pkg::LIMIT_BITS-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (joins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        miter_limit = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit gaps);
        t_join dummy;
        dummy = '{default: '0};
        allow_gaps = gaps;
        for (int i = 0; i < count; i++) send_word(rand_word(), 1'b0, dummy);
    endtask

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_join e;
        if (i_rst_n && o_done) begin
            if (joins_due.size() == 0) begin
                $error("join result with nothing outstanding");
                n_errors++;
            end else begin
                e = joins_due.pop_front();
                if (o_join_kind <= 2) kind_seen[o_join_kind]++;
                if (o_join_kind !== e.kind) begin
                    $error("join_kind: expected %0d, got %0d", e.kind, o_join_kind);
                    n_errors++;
                end
                if (o_join_x !== e.jx) begin
                    $error("join_x: expected %0d, got %0d", e.jx, o_join_x);
                    n_errors++;
                end
                if (o_join_y !== e.jy) begin
                    $error("join_y: expected %0d, got %0d", e.jy, o_join_y);
                    n_errors++;
                end
                if (o_bevel_x !== e.bvx) begin
                    $error("bevel_x: expected %0d, got %0d", e.bvx, o_bevel_x);
                    n_errors++;
                end
                if (o_bevel_y !== e.bvy) begin
                    $error("bevel_y: expected %0d, got %0d", e.bvy, o_bevel_y);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d joins outstanding", joins_due.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // directed rows
    function automatic void build_rows(ref t_row rows[$]);
        t_row r;
        t_word z;
        for (int i = 0; i < 12; i++) z[i] = '0;
        // all zero: degenerate, midpoint at origin
        r.f = z; r.typed = 1; r.res = '{sjs_pkg::JK_NONE, 0, 0, 0, 0};
        rows.insert(rows.size(), r);
        // all at the top of the range
        for (int i = 0; i < 12; i++) r.f[i] = CMAX;
        r.res = '{sjs_pkg::JK_NONE, CMAX, CMAX, 0, 0};
        rows.insert(rows.size(), r);
        // all at the bottom of the range
        for (int i = 0; i < 12; i++) r.f[i] = CMIN;
        r.res = '{sjs_pkg::JK_NONE, CMIN, CMIN, 0, 0};
        rows.insert(rows.size(), r);
        r.typed = 0;
        // right angle, intersection at b
        r.f = z; r.f[BX] = 256; r.f[CX] = 256; r.f[DX] = 256; r.f[DY] = 256;
        rows.insert(rows.size(), r);
        // intersection at a (t = 0)
        r.f = z; r.f[BX] = 256; r.f[DY] = 512;
        rows.insert(rows.size(), r);
        // intersection beyond b, moderate: miter
        r.f = z; r.f[BX] = 256; r.f[CX] = 300; r.f[CY] = 40; r.f[DX] = 340; r.f[DY] = 100;
        rows.insert(rows.size(), r);
        // sharp angle, far intersection: bevel
        r.f = z; r.f[BX] = 2560; r.f[CX] = 2560; r.f[CY] = 256; r.f[DX] = 0; r.f[DY] = 257;
        r.f[PDX] = 100; r.f[PDY] = -50; r.f[QDX] = -30; r.f[QDY] = 70;
        rows.insert(rows.size(), r);
        // bevel corners pushed past both ends
        r.f[BX] = CMAX; r.f[AX] = CMAX - 2560; r.f[CX] = CMIN; r.f[DX] = CMIN + 2560;
        r.f[PDX] = CMAX; r.f[PDY] = CMIN; r.f[QDX] = CMAX; r.f[QDY] = CMIN;
        rows.insert(rows.size(), r);
        // intersection behind a (t < 0)
        r.f = z; r.f[AX] = 1000; r.f[BX] = 2000; r.f[CX] = -5; r.f[CY] = 7; r.f[DX] = -3;
        r.f[DY] = -9;
        rows.insert(rows.size(), r);
        // parallel with odd negative sum: floor rounding
        r.f = z; r.f[AX] = -10; r.f[BX] = -3; r.f[CX] = -2; r.f[BY] = -1; r.f[AY] = -1;
        r.f[DX] = 9; r.f[CY] = 0; r.f[DY] = 0;
        rows.insert(rows.size(), r);
        // diagonal edge meeting a vertical one exactly at b
        r.f = z; r.f[BX] = 1; r.f[BY] = 1; r.f[CX] = 1; r.f[DX] = 1; r.f[DY] = 2;
        rows.insert(rows.size(), r);
        // intersection far outside the range: bevel
        r.f = z; r.f[AX] = CMAX - 1; r.f[BX] = CMAX; r.f[CY] = 5; r.f[DX] = 1; r.f[DY] = 5;
        r.f[AY] = CMIN; r.f[BY] = CMIN + 1;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        t_row rows[$];
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_prev_start_x = '0; i_prev_start_y = '0; i_prev_end_x = '0; i_prev_end_y = '0;
        i_cur_start_x  = '0; i_cur_start_y  = '0; i_cur_end_x  = '0; i_cur_end_y  = '0;
        i_prev_dir_x   = '0; i_prev_dir_y   = '0; i_cur_dir_x  = '0; i_cur_dir_y  = '0;
        miter_limit = sjs_pkg::LIMIT_RESET;
        n_errors = 0;
        n_words = 0;
        idle_cycles = 0;
        allow_gaps = 1;
        kind_seen = '{0, 0, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset limit
        build_rows(rows);
        foreach (rows[i]) send_word(rows[i].f, rows[i].typed, rows[i].res);

        // random words over a sweep of limits; one stretch with no gaps
        set_limit('0);
        run_random(N_RANDOM / 5, 1);
        set_limit(LIM_MAX);
        run_random(N_RANDOM / 5, 0);
        set_limit(sjs_pkg::LIMIT_RESET);
        run_random(N_RANDOM / 5, 1);
        set_limit(sjs_pkg::LIMIT_BITS'($urandom_range(0, 1 << 20)));
        run_random(N_RANDOM / 5, 1);
        set_limit(sjs_pkg::LIMIT_BITS'($urandom));
        run_random(N_RANDOM / 5, 1);

        // wait out the pipe
        start <= 1'b0;
        while (joins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d words sent over 6 limit settings", n_words);
        $display("joins seen: %0d midpoint, %0d miter, %0d bevel",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/sjs_pkg.sv
rtl/core/sjs_div.sv
rtl/core/stroke_join_solver.sv
dv/tb.sv
